@@ rtl/wrct_pkg.sv @@
// Shared constants, command and status codes, and control structs of the weak-reference table.
package wrct_pkg;

   localparam int CMD_W       = 3;
   localparam int IDX_W       = 10;
   localparam int CFG_W       = 11;
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 31;
   localparam int STATUS_W    = 3;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic [CFG_W-1:0]   USABLE_RESET = 11'd1024;
   localparam logic [WORD_W-1:0]  ALIVE_WORD   = 32'h8000_0000;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 31'h7FFF_FFFF;

   // command codes; anything above CMD_QUERY behaves as a query
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ALIAS   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNALLOC = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the request word and start the table read
      logic commit;    // apply the update and load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // result register can take a new word this cycle
   } dp_status_type;

endpackage

@@ rtl/wrct_if.sv @@
// Handshake interfaces for request, response and register-write channels.
interface wrct_req_if;
   import wrct_pkg::*;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [IDX_W-1:0]   entry_index;
   modport source (output valid, output cmd, output entry_index, input ready);
   modport sink   (input valid, input cmd, input entry_index, output ready);
endinterface

interface wrct_rsp_if;
   import wrct_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    result_index;
   logic                is_alive;
   logic [COUNT_W-1:0]  ref_count;
   logic                released;
   logic [STATUS_W-1:0] status;
   modport source (output valid, output result_index, output is_alive, output ref_count,
                   output released, output status, input ready);
   modport sink   (input valid, input result_index, input is_alive, input ref_count,
                   input released, input status, output ready);
endinterface

interface wrct_csr_if;
   import wrct_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/weak_ref_count_table.sv @@
// Top level of the weak-reference count table with free list.
//
//   channel   dir  words carried                                       handshake
//   req_chan  in   cmd, entry_index                                    valid/ready
//   rsp_chan  out  result_index, is_alive, ref_count, released, status valid/ready
//   csr_chan  in   usable_entries                                      valid/ready
//
// Each request word is first read: the addressed entry (or the free-list head for
// allocate) comes from the synchronous table RAM; then it is modified, written
// back and loaded into the result register. The single RAM read port sets this.
// A result waiting in the output register does not stop the next request from
// being read; a stalled response holds the commit until the register frees.
// Reset clears the head and high-water mark at once; the table needs no sweep.
module weak_ref_count_table #(
   parameter int TABLE_DEPTH = wrct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   wrct_req_if.sink    req_chan,
   wrct_rsp_if.source  rsp_chan,
   wrct_csr_if.sink    csr_chan
);
   import wrct_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // sequence each word: capture and read, then commit
   wrct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // table, list state and result register
   wrct_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_cmd          (req_chan.cmd),
      .req_entry_index  (req_chan.entry_index),
      .csr_valid        (csr_chan.valid),
      .csr_ready        (csr_chan.ready),
      .csr_data         (csr_chan.data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_result_index (rsp_chan.result_index),
      .rsp_is_alive     (rsp_chan.is_alive),
      .rsp_ref_count    (rsp_chan.ref_count),
      .rsp_released     (rsp_chan.released),
      .rsp_status       (rsp_chan.status)
   );

endmodule

@@ rtl/wrct_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module wrct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/wrct_ctrl.sv @@
// Controller: sequences each request through table read and commit.
module wrct_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wrct_pkg::dp_status_type status,
   output wrct_pkg::ctrl_cmd_type  cmd
);
   import wrct_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               state_in = S_EXEC;
               ready_in = 1'b0;
            end
         end
         S_EXEC: begin
            // hold until the result register is free
            if (status.out_free) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready   = ready_ff;
   assign cmd.capture = req_valid && ready_ff;
   assign cmd.commit  = (state_ff == S_EXEC) && status.out_free;

endmodule

@@ rtl/wrct_dp.sv @@
// Datapath: entry table, free-list head, high-water mark and result register.
module wrct_dp #(
   parameter int TABLE_DEPTH = wrct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wrct_pkg::ctrl_cmd_type          cmd,
   output wrct_pkg::dp_status_type         status,
   input  logic [wrct_pkg::CMD_W-1:0]      req_cmd,
   input  logic [wrct_pkg::IDX_W-1:0]      req_entry_index,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wrct_pkg::CFG_W-1:0]      csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [wrct_pkg::IDX_W-1:0]      rsp_result_index,
   output logic                            rsp_is_alive,
   output logic [wrct_pkg::COUNT_W-1:0]    rsp_ref_count,
   output logic                            rsp_released,
   output logic [wrct_pkg::STATUS_W-1:0]   rsp_status
);
   import wrct_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (PW > CFG_W) ? PW : CFG_W;

   // configuration
   logic [CFG_W-1:0]   usable_ff, usable_in;
   // captured request
   logic [CMD_W-1:0]   cmd_ff;
   logic [IDX_W-1:0]   idx_ff;
   // list state
   logic [COUNT_W-1:0] head_ff, head_in;
   logic [PW-1:0]      hw_ff, hw_in;
   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    out_idx_ff, out_idx_in;
   logic [WORD_W-1:0]   out_word_ff, out_word_in;
   logic                out_rel_ff, out_rel_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   // table port
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic [CW-1:0]     depth_wide, usable_wide, limit, hw_wide, idx_wide, req_idx_wide;
   logic [CW-1:0]     got_wide;
   logic [PW-1:0]     hw_next;
   logic              head_valid;
   logic [WORD_W-1:0] upd_word;
   logic              release_entry;

   assign csr_ready = 1'b1;
   assign usable_in = (csr_valid && csr_ready) ? csr_data : usable_ff;

   assign depth_wide   = CW'(TABLE_DEPTH);
   assign usable_wide  = CW'(usable_ff);
   assign limit        = (usable_wide < depth_wide) ? usable_wide : depth_wide;
   assign hw_wide      = CW'(hw_ff);
   assign idx_wide     = CW'(idx_ff);
   assign req_idx_wide = CW'(req_entry_index);
   assign hw_next      = hw_ff + PW'(1);
   assign head_valid   = head_ff < COUNT_W'(hw_ff);

   // allocate reads the chain head, every other command the addressed entry
   assign rd_addr = (req_cmd == CMD_ALLOC) ? head_ff[AW-1:0] : req_idx_wide[AW-1:0];

   wrct_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en && cmd.commit),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = idx_wide[AW-1:0];
      wr_data       = rd_data;
      head_in       = head_ff;
      hw_in         = hw_ff;
      got_wide      = '0;
      upd_word      = rd_data;
      release_entry = 1'b0;
      out_idx_in    = idx_ff;
      out_word_in   = '0;
      out_rel_in    = 1'b0;
      out_status_in = ST_OK;

      if (cmd_ff == CMD_ALLOC) begin
         priority if (head_valid) begin
            // pop the chain: the entry holds the next link
            got_wide    = head_ff[CW-1:0];
            head_in     = rd_data[COUNT_W-1:0];
            wr_en       = 1'b1;
            wr_addr     = got_wide[AW-1:0];
            wr_data     = ALIVE_WORD;
            out_idx_in  = got_wide[IDX_W-1:0];
            out_word_in = ALIVE_WORD;
         end else if (hw_wide < limit) begin
            // fresh entry above the high-water mark
            got_wide    = hw_wide;
            hw_in       = hw_next;
            head_in     = COUNT_W'(hw_next);
            wr_en       = 1'b1;
            wr_addr     = got_wide[AW-1:0];
            wr_data     = ALIVE_WORD;
            out_idx_in  = got_wide[IDX_W-1:0];
            out_word_in = ALIVE_WORD;
         end else begin
            out_idx_in    = '0;
            out_status_in = ST_FULL;
         end
      end else if (idx_wide >= hw_wide) begin
         out_status_in = ST_UNALLOC;
      end else begin
         unique case (cmd_ff)
            CMD_DESTROY: begin
               upd_word      = {1'b0, rd_data[COUNT_W-1:0]};
               wr_en         = 1'b1;
               release_entry = (upd_word == '0);
               out_word_in   = upd_word;
            end
            CMD_ALIAS: begin
               if (rd_data[COUNT_W-1:0] == COUNT_MAX) begin
                  out_word_in   = rd_data;
                  out_status_in = ST_OVER;
               end else begin
                  upd_word    = rd_data + WORD_W'(1);
                  wr_en       = 1'b1;
                  out_word_in = upd_word;
               end
            end
            CMD_DISCARD: begin
               if (rd_data[COUNT_W-1:0] == '0) begin
                  out_word_in   = rd_data;
                  out_status_in = ST_UNDER;
               end else begin
                  upd_word      = rd_data - WORD_W'(1);
                  wr_en         = 1'b1;
                  release_entry = (upd_word == '0);
                  out_word_in   = upd_word;
               end
            end
            default: begin
               out_word_in = rd_data;
            end
         endcase

         if (release_entry) begin
            // push onto the chain
            wr_data    = {1'b0, head_ff};
            head_in    = COUNT_W'(idx_ff);
            out_rel_in = 1'b1;
         end else begin
            wr_data = upd_word;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in    = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff    <= USABLE_RESET;
         head_ff      <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         usable_ff    <= usable_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            head_ff <= head_in;
            hw_ff   <= hw_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_entry_index;
      end
      if (cmd.commit) begin
         out_idx_ff    <= out_idx_in;
         out_word_ff   <= out_word_in;
         out_rel_ff    <= out_rel_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = out_idx_ff;
   assign rsp_is_alive     = out_word_ff[WORD_W-1];
   assign rsp_ref_count    = out_word_ff[COUNT_W-1:0];
   assign rsp_released     = out_rel_ff;
   assign rsp_status       = out_status_ff;

endmodule
